### rtl/core/bbc_pkg.sv
`timescale 1ns / 1ps

package bbc_pkg;

	// Bracket characters
	localparam logic [7:0] CH_ROUND_OPEN   = 8'h28; // (
	localparam logic [7:0] CH_ROUND_CLOSE  = 8'h29; // )
	localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B; // [
	localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D; // ]
	localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B; // {
	localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D; // }

	// Bracket kind as stored on the stack
	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_ROUND  = 2'd1,
		KIND_SQUARE = 2'd2,
		KIND_CURLY  = 2'd3
	} kind_t;

	// Verdict codes; the error codes double as the held error
	typedef enum logic [2:0] {
		V_PENDING  = 3'd0,
		V_VALID    = 3'd1,
		V_MISMATCH = 3'd2,
		V_EMPTY    = 3'd3,
		V_UNCLOSED = 3'd4,
		V_OVERFLOW = 3'd5
	} verdict_t;

	localparam int unsigned DEPTH_OUT_W = 6;

	// Input request payload
	typedef struct packed {
		logic [7:0] character;
		logic       last_char;
	} char_req_t;

	// Result payload
	typedef struct packed {
		logic [2:0]             verdict;
		logic                   string_done;
		logic [DEPTH_OUT_W-1:0] open_depth;
	} result_t;

	function automatic kind_t opener_kind(input logic [7:0] ch);
		kind_t k;
		k = KIND_NONE;
		if (ch == CH_ROUND_OPEN)  k = KIND_ROUND;
		if (ch == CH_SQUARE_OPEN) k = KIND_SQUARE;
		if (ch == CH_CURLY_OPEN)  k = KIND_CURLY;
		return k;
	endfunction

	function automatic kind_t closer_kind(input logic [7:0] ch);
		kind_t k;
		k = KIND_NONE;
		if (ch == CH_ROUND_CLOSE)  k = KIND_ROUND;
		if (ch == CH_SQUARE_CLOSE) k = KIND_SQUARE;
		if (ch == CH_CURLY_CLOSE)  k = KIND_CURLY;
		return k;
	endfunction

endpackage

### rtl/core/bbc_stream_if.sv
`timescale 1ns / 1ps

// Valid/ready channel carrying one request of type T
interface bbc_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/bbc_stack_mem.sv
`timescale 1ns / 1ps

// Kind stack storage: one write port, one registered read port.
// A write to the address being read in the same cycle is forwarded.
module bbc_stack_mem #(
	parameter int unsigned STACK_DEPTH = 32,
	parameter int unsigned AW          = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  bbc_pkg::kind_t  wdata,
	input  logic [AW-1:0]   raddr,
	output bbc_pkg::kind_t  rdata
);
	import bbc_pkg::*;

	kind_t mem [STACK_DEPTH];
	kind_t rd_q;
	kind_t fwd_data_q;
	logic  fwd_q;

	// Storage and synchronous read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q       <= mem[raddr];
		fwd_data_q <= wdata;
	end

	// Write-to-read bypass flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= we && (waddr == raddr);
		end
	end

	assign rdata = fwd_q ? fwd_data_q : rd_q;

endmodule

### rtl/core/bbc_ctrl.sv
`timescale 1ns / 1ps

// Stack pointer, held error and verdict. The read address always tracks the
// entry that will be on top after this cycle, so the top kind is ready for
// the next character.
module bbc_ctrl #(
	parameter int unsigned STACK_DEPTH = 32,
	parameter int unsigned AW          = 5,
	parameter int unsigned CW          = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  bbc_pkg::char_req_t  req,
	input  bbc_pkg::kind_t      top,
	output logic                we,
	output logic [AW-1:0]       waddr,
	output bbc_pkg::kind_t      wdata,
	output logic [AW-1:0]       raddr,
	output bbc_pkg::result_t    res
);
	import bbc_pkg::*;

	logic [CW-1:0] count_q;
	verdict_t      err_q;

	kind_t         op;
	kind_t         cl;
	logic [CW-1:0] count_after;
	verdict_t      err_after;
	logic [CW-1:0] count_next;
	verdict_t      err_next;
	logic [CW-1:0] rd_ptr;
	logic          push;

	assign op = opener_kind(req.character);
	assign cl = closer_kind(req.character);

	// Apply one character to the stack
	always_comb begin
		count_after = count_q;
		err_after   = err_q;
		push        = 1'b0;
		if (err_q == V_PENDING) begin
			if (op != KIND_NONE) begin
				if (count_q == CW'(STACK_DEPTH)) begin
					err_after = V_OVERFLOW;
				end else begin
					push        = 1'b1;
					count_after = count_q + CW'(1);
				end
			end else if (cl != KIND_NONE) begin
				if (count_q == '0) begin
					err_after = V_EMPTY;
				end else if (top == cl) begin
					count_after = count_q - CW'(1);
				end else begin
					err_after = V_MISMATCH;
				end
			end
		end
	end

	// Result fields
	always_comb begin
		res.open_depth  = DEPTH_OUT_W'(count_after);
		res.string_done = req.last_char;
		if (!req.last_char) begin
			res.verdict = V_PENDING;
		end else if (err_after != V_PENDING) begin
			res.verdict = err_after;
		end else if (count_after != '0) begin
			res.verdict = V_UNCLOSED;
		end else begin
			res.verdict = V_VALID;
		end
	end

	// Next state; end of string clears everything
	always_comb begin
		count_next = count_q;
		err_next   = err_q;
		if (take) begin
			count_next = req.last_char ? '0 : count_after;
			err_next   = req.last_char ? V_PENDING : err_after;
		end
	end

	assign we     = take && push;
	assign waddr  = count_q[AW-1:0];
	assign wdata  = op;
	assign rd_ptr = count_next - CW'(1);
	assign raddr  = rd_ptr[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q   <= V_PENDING;
		end else begin
			count_q <= count_next;
			err_q   <= err_next;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && req.last_char |=> count_q == '0 && err_q == V_PENDING)
		else $error("state not cleared after last character");

	a_error_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		take && !req.last_char && err_q != V_PENDING
		|=> $stable(count_q) && $stable(err_q))
		else $error("held error did not freeze the stack");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> count_q < CW'(STACK_DEPTH) && err_q == V_PENDING)
		else $error("push beyond stack or during held error");

endmodule

### rtl/core/bbc_out_fifo.sv
`timescale 1ns / 1ps

// Two-entry result queue; takes a new result while an older one is stalled.
module bbc_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bbc_pkg::result_t  push_data,
	output logic              can_push,
	output logic              out_valid,
	input  logic              out_ready,
	output bbc_pkg::result_t  out_data
);
	import bbc_pkg::*;

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign can_push  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = entry_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// Payload storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("result queue count out of range");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
		else $error("result queue pointers disagree with count");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && !out_ready |=> cnt_q == 2'd2)
		else $error("result queue lost an entry while stalled");

endmodule

### rtl/core/bracket_balance_checker.sv
`timescale 1ns / 1ps

// Bracket balance checker. Takes one character request per cycle on chars
// (character plus last_char mark) and returns exactly one result request per
// character on results: verdict, string_done and open_depth. Verdict is 0
// (pending) except on the last character, where it is 1 (valid) or the first
// error of the string: 2 mismatched closer, 3 closer on empty stack, 4
// unclosed opener, 5 stack overflow. The first error freezes the stack until
// the string ends; the last character clears the checker for the next string.
// Throughput is one character per cycle while the result queue has room; each
// result is registered in the result queue. The stack is a kind stack memory
// with one write and one registered read port whose read always holds the next
// top-of-stack, with same-cycle write forwarding. A two-entry result queue keeps
// input flowing while one result waits. No clearing pass follows reset.
module bracket_balance_checker #(
	parameter int unsigned STACK_DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	bbc_stream_if.sink   chars,
	bbc_stream_if.source results
);
	import bbc_pkg::*;

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	logic          take;
	logic          can_push;
	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	kind_t         wdata;
	kind_t         top;
	result_t       res;
	char_req_t     req;
	result_t       out_data;

	assign req          = chars.data;
	assign chars.ready  = can_push;
	assign take         = chars.valid && can_push;
	assign results.data = out_data;

	bbc_stack_mem #(
		.STACK_DEPTH (STACK_DEPTH),
		.AW          (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (raddr),
		.rdata  (top)
	);

	bbc_ctrl #(
		.STACK_DEPTH (STACK_DEPTH),
		.AW          (AW),
		.CW          (CW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.req    (req),
		.top    (top),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (raddr),
		.res    (res)
	);

	bbc_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (res),
		.can_push  (can_push),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_data  (out_data)
	);

endmodule

### dv/bbc_result_checker.sv
`timescale 1ns / 1ps

// Scoreboard for the bracket balance checker. Tracks its own bracket stack
// from every accepted character request and compares each result request
// with the oldest prediction.
module bbc_result_checker #(
	parameter int unsigned STACK_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               chars_valid,
	input  logic               chars_ready,
	input  bbc_pkg::char_req_t chars_data,
	input  logic               results_valid,
	input  logic               results_ready,
	input  bbc_pkg::result_t   results_data,
	output int unsigned        mismatch_count,
	output int unsigned        outstanding,
	output int unsigned        results_checked
);
	import bbc_pkg::*;

	localparam int unsigned REPORT_LIMIT = 10;

	// Predicted bracket stack and held error
	kind_t       kind_mem [STACK_DEPTH];
	int unsigned open_count;
	verdict_t    held_error;

	// Results predicted but not yet seen, oldest first
	result_t     expected_results [$];
	int unsigned bad_total;
	int unsigned checked_total;

	// Advance the stack by one character and return the result it yields
	function automatic result_t predict_bracket_result(input char_req_t req);
		result_t res;
		kind_t   kind;
		logic    opens;
		logic    closes;

		case (req.character)
			CH_ROUND_OPEN, CH_ROUND_CLOSE:   kind = KIND_ROUND;
			CH_SQUARE_OPEN, CH_SQUARE_CLOSE: kind = KIND_SQUARE;
			CH_CURLY_OPEN, CH_CURLY_CLOSE:   kind = KIND_CURLY;
			default:                         kind = KIND_NONE;
		endcase
		opens  = req.character inside {CH_ROUND_OPEN, CH_SQUARE_OPEN, CH_CURLY_OPEN};
		closes = (kind != KIND_NONE) && !opens;

		// once an error is held the stack stays frozen until the string ends
		if (held_error == V_PENDING) begin
			if (opens) begin
				if (open_count >= STACK_DEPTH) begin
					held_error = V_OVERFLOW;
				end else begin
					kind_mem[open_count] = kind;
					open_count++;
				end
			end else if (closes) begin
				if (open_count == 0) begin
					held_error = V_EMPTY;
				end else if (kind_mem[open_count - 1] == kind) begin
					open_count--;
				end else begin
					held_error = V_MISMATCH;
				end
			end
		end

		res.open_depth  = open_count[DEPTH_OUT_W-1:0];
		res.string_done = req.last_char;
		res.verdict     = V_PENDING;

		// final verdict on the last character, then start clean
		if (req.last_char) begin
			if (held_error != V_PENDING) begin
				res.verdict = held_error;
			end else if (open_count != 0) begin
				res.verdict = V_UNCLOSED;
			end else begin
				res.verdict = V_VALID;
			end
			open_count = 0;
			held_error = V_PENDING;
		end
		return res;
	endfunction

	// Predict on accepted characters first, so a same-edge result still finds it
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			open_count    = 0;
			held_error    = V_PENDING;
			bad_total     = 0;
			checked_total = 0;
			expected_results.delete();
		end else begin
			if (chars_valid && chars_ready) begin
				expected_results.push_back(predict_bracket_result(chars_data));
			end
			if (results_valid && results_ready) begin
				if (expected_results.size() == 0) begin
					bad_total++;
					if (bad_total <= REPORT_LIMIT) begin
						$display("[%0t] unexpected result: verdict=%0d done=%0d depth=%0d",
							$time, results_data.verdict, results_data.string_done,
							results_data.open_depth);
					end
				end else begin
					want = expected_results.pop_front();
					checked_total++;
					if (results_data.verdict !== want.verdict ||
							results_data.string_done !== want.string_done ||
							results_data.open_depth !== want.open_depth) begin
						bad_total++;
						if (bad_total <= REPORT_LIMIT) begin
							$display({"[%0t] result mismatch: ",
								"expected verdict=%0d done=%0d depth=%0d, ",
								"got verdict=%0d done=%0d depth=%0d"},
								$time, want.verdict, want.string_done, want.open_depth,
								results_data.verdict, results_data.string_done,
								results_data.open_depth);
						end
					end
				end
			end
		end
		mismatch_count  <= bad_total;
		outstanding     <= expected_results.size();
		results_checked <= checked_total;
	end

endmodule

### dv/bracket_balance_checker_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the bracket balance checker: directed strings for
// each verdict but overflow, then random well-formed, damaged, deep and noise strings.
module bracket_balance_checker_tb;
	import bbc_pkg::*;

	localparam int unsigned STACK_DEPTH  = 32;
	localparam int unsigned ITEM_TARGET  = 1550;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 16;

	typedef enum int unsigned {
		STR_CLEAN,
		STR_DAMAGED,
		STR_DEEP,
		STR_NOISE
	} text_style_t;

	typedef enum int unsigned {
		READY_ALWAYS,
		READY_COIN,
		READY_PERIODIC,
		READY_SPARSE
	} ready_mode_t;

	logic clk;
	logic arst_n;

	bbc_stream_if #(.T(char_req_t)) chars_if ();
	bbc_stream_if #(.T(result_t))   results_if ();

	int unsigned mismatch_count;
	int unsigned outstanding;
	int unsigned results_checked;
	int unsigned chars_sent;
	int unsigned strings_sent;
	int unsigned burst_left;
	int unsigned cycle_count;
	int unsigned style_hits [4];
	logic [7:0]  text_buf [$];

	ready_mode_t ready_mode;
	int unsigned ready_left;
	int unsigned ready_phase;

	bracket_balance_checker #(.STACK_DEPTH(STACK_DEPTH)) DUT (
		.clk,
		.arst_n,
		.chars   (chars_if),
		.results (results_if)
	);

	bbc_result_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
		.clk,
		.arst_n,
		.chars_valid     (chars_if.valid),
		.chars_ready     (chars_if.ready),
		.chars_data      (chars_if.data),
		.results_valid   (results_if.valid),
		.results_ready   (results_if.ready),
		.results_data    (results_if.data),
		.mismatch_count  (mismatch_count),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Cycle budget
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with results still due", cycle_count);
		$display("FAIL");
		$finish;
	end

	// Result side: randomly chosen back-pressure modes
	initial begin
		results_if.ready = 1'b0;
		ready_mode       = READY_ALWAYS;
		ready_left       = 0;
		ready_phase      = 0;
	end

	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode <= ready_mode_t'($urandom_range(0, 3));
			ready_left <= $urandom_range(8, 80);
		end else begin
			ready_left <= ready_left - 1;
		end
		ready_phase <= ready_phase + 1;
		case (ready_mode)
			READY_ALWAYS:   results_if.ready <= 1'b1;
			READY_COIN:     results_if.ready <= 1'($urandom_range(0, 1));
			READY_PERIODIC: results_if.ready <= (ready_phase % 5) >= 2;
			default:        results_if.ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	function automatic logic [7:0] opener_char(input kind_t k);
		case (k)
			KIND_ROUND:  return CH_ROUND_OPEN;
			KIND_SQUARE: return CH_SQUARE_OPEN;
			default:     return CH_CURLY_OPEN;
		endcase
	endfunction

	function automatic logic [7:0] closer_char(input kind_t k);
		case (k)
			KIND_ROUND:  return CH_ROUND_CLOSE;
			KIND_SQUARE: return CH_SQUARE_CLOSE;
			default:     return CH_CURLY_CLOSE;
		endcase
	endfunction

	function automatic logic [7:0] random_bracket();
		kind_t k;
		k = kind_t'($urandom_range(1, 3));
		return $urandom_range(0, 1) ? opener_char(k) : closer_char(k);
	endfunction

	// One character request; valid stays up through a burst, gaps between bursts
	task automatic send_char(input logic [7:0] ch, input logic last);
		char_req_t   req;
		int unsigned gap;
		req.character = ch;
		req.last_char = last;
		chars_if.valid <= 1'b1;
		chars_if.data  <= req;
		do @(posedge clk); while (!chars_if.ready);
		chars_sent++;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(10, 60);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				chars_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_text();
		foreach (text_buf[i]) begin
			send_char(text_buf[i], i == text_buf.size() - 1);
		end
		strings_sent++;
	endtask

	task automatic send_literal(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++) begin
			text_buf.push_back(s[i]);
		end
		send_text();
	endtask

	// Hold off the sender until every predicted result has come back
	task automatic drain_results();
		chars_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Properly nested brackets mixed with non-bracket bytes
	task automatic build_clean(input int unsigned max_depth, input int unsigned steps);
		kind_t       open_kinds [$];
		kind_t       k;
		int unsigned pick;
		logic [7:0]  b;
		text_buf.delete();
		repeat (steps) begin
			pick = $urandom_range(0, 9);
			if (pick < 4 && open_kinds.size() < max_depth) begin
				k = kind_t'($urandom_range(1, 3));
				open_kinds.push_back(k);
				text_buf.push_back(opener_char(k));
			end else if (pick < 7 && open_kinds.size() != 0) begin
				text_buf.push_back(closer_char(open_kinds.pop_back()));
			end else begin
				do b = 8'($urandom_range(0, 255));
				while (b inside {CH_ROUND_OPEN, CH_ROUND_CLOSE, CH_SQUARE_OPEN,
					CH_SQUARE_CLOSE, CH_CURLY_OPEN, CH_CURLY_CLOSE});
				text_buf.push_back(b);
			end
		end
		while (open_kinds.size() != 0) begin
			text_buf.push_back(closer_char(open_kinds.pop_back()));
		end
	endtask

	initial begin : stimulus
		text_style_t style;
		kind_t       kinds [$];
		kind_t       k;
		int unsigned pick;
		int unsigned idx;
		int unsigned depth_goal;
		int unsigned random_start;

		arst_n         = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.data  = '0;
		chars_sent     = 0;
		strings_sent   = 0;
		burst_left     = 0;
		foreach (style_hits[i]) style_hits[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every verdict but overflow, all six brackets, byte extremes
		send_literal("()");
		send_literal("[{}]");
		send_literal("([)]}");   // mismatch, the rest is ignored while held
		send_literal(")");       // closer on empty, one-character string
		send_literal("{(");      // unclosed openers
		send_literal("](");      // empty-stack error survives a later opener
		send_literal("(}");
		text_buf = '{8'h00, 8'h61, 8'hFF};
		send_text();
		drain_results();

		// Random strings; the first deep one always overflows the stack
		random_start = chars_sent;
		while (chars_sent - random_start < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (style_hits[STR_DEEP] == 0) begin
				style = STR_DEEP;
			end else if (pick < 45) begin
				style = STR_CLEAN;
			end else if (pick < 70) begin
				style = STR_DAMAGED;
			end else if (pick < 73) begin
				style = STR_DEEP;
			end else begin
				style = STR_NOISE;
			end

			case (style)
				STR_CLEAN: begin
					build_clean($urandom_range(1, 6), $urandom_range(1, 16));
				end
				STR_DAMAGED: begin
					// drop, overwrite or insert one byte of a nested string
					build_clean($urandom_range(1, 6), $urandom_range(2, 16));
					idx = $urandom_range(0, text_buf.size() - 1);
					case ($urandom_range(0, 2))
						0: if (text_buf.size() > 1) text_buf.delete(idx);
						1: text_buf[idx] = random_bracket();
						default: text_buf.insert(idx, random_bracket());
					endcase
				end
				STR_DEEP: begin
					text_buf.delete();
					kinds.delete();
					depth_goal = (style_hits[STR_DEEP] == 0) ? STACK_DEPTH + 1 :
						$urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 4);
					repeat (depth_goal) begin
						k = kind_t'($urandom_range(1, 3));
						kinds.push_back(k);
						text_buf.push_back(opener_char(k));
					end
					repeat ($urandom_range(0, 1) ? depth_goal : $urandom_range(0, depth_goal)) begin
						text_buf.push_back(closer_char(kinds.pop_back()));
					end
				end
				default: begin
					text_buf.delete();
					repeat ($urandom_range(1, 12)) begin
						text_buf.push_back($urandom_range(0, 1) ? random_bracket() :
							8'($urandom_range(0, 255)));
					end
				end
			endcase
			style_hits[style]++;
			send_text();
			if ($urandom_range(0, 49) == 0) begin
				drain_results();
			end
		end

		// Wind down: everything back, then idle for stray results
		chars_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters in %0d strings: %0d well-formed, %0d damaged,",
			chars_sent, strings_sent, style_hits[STR_CLEAN], style_hits[STR_DAMAGED]);
		$display("%0d deep, %0d noise; compared %0d results under sender gaps and stalls",
			style_hits[STR_DEEP], style_hits[STR_NOISE], results_checked);
		if (outstanding != 0) begin
			$display("%0d predicted results never arrived", outstanding);
		end
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/bbc_pkg.sv
rtl/core/bbc_stream_if.sv
rtl/core/bbc_stack_mem.sv
rtl/core/bbc_ctrl.sv
rtl/core/bbc_out_fifo.sv
rtl/core/bracket_balance_checker.sv
dv/bbc_result_checker.sv
dv/bracket_balance_checker_tb.sv
